[hdl/hrd_pkg.sv]
// hrd_pkg: shared types, constants and the header-prefix table for the
// HTTP request deframer. No dependencies; imported by every hdl module.
package hrd_pkg;

    // Field and counter widths
    localparam int LENGTH_BITS       = 24;
    localparam int HEADER_COUNT_BITS = 17;
    localparam int MAX_DIGITS        = 31;
    localparam int DIGIT_CNT_BITS    = 5;
    localparam int PREFIX_LEN        = 15;
    localparam int POS_BITS          = 4;
    localparam int CFG_IDX_BITS      = 1;
    localparam int CFG_DATA_BITS     = 24;

    // Digit accumulator saturates at 2^LENGTH_BITS, one bit wider than the length
    localparam int ACC_BITS = LENGTH_BITS + 1;
    localparam logic [ACC_BITS-1:0] LEN_SAT = ACC_BITS'(1) << LENGTH_BITS;

    // Room for accumulator times ten plus one digit
    localparam int MUL_BITS = ACC_BITS + 4;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_HEADER = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_BODY   = 1'b1;
    localparam logic [HEADER_COUNT_BITS-1:0] MAX_HEADER_RESET = HEADER_COUNT_BITS'(16 * 1024);
    localparam logic [LENGTH_BITS-1:0] MAX_BODY_RESET = LENGTH_BITS'(10 * 1024 * 1024);

    // Characters of interest
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_UC_A = 8'h41;
    localparam logic [7:0] CH_UC_Z = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    // Result codes
    typedef enum logic [2:0] {
        KIND_HEADER  = 3'd0,
        KIND_TERM    = 3'd1,
        KIND_BODY    = 3'd2,
        KIND_IGNORED = 3'd3,
        KIND_ERROR   = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_HEADER = 2'd1,
        ERR_BODY   = 2'd2,
        ERR_CLOSED = 2'd3
    } t_err;

    // Classified input word, front to back
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] lower;
        logic [3:0] digit;
        logic       is_cr;
        logic       is_lf;
        logic       is_digit;
        logic       first;
        logic       closed;
    } t_cls;

    // Result word
    typedef struct packed {
        t_kind                  kind;
        logic [7:0]             data;
        logic [LENGTH_BITS-1:0] body_length;
        logic                   last;
        t_err                   err;
    } t_res;

    // "content-length:" by position
    function automatic logic [7:0] prefix_char(input logic [POS_BITS-1:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = "c";
            4'd1:    ch = "o";
            4'd2:    ch = "n";
            4'd3:    ch = "t";
            4'd4:    ch = "e";
            4'd5:    ch = "n";
            4'd6:    ch = "t";
            4'd7:    ch = "-";
            4'd8:    ch = "l";
            4'd9:    ch = "e";
            4'd10:   ch = "n";
            4'd11:   ch = "g";
            4'd12:   ch = "t";
            4'd13:   ch = "h";
            4'd14:   ch = ":";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

[hdl/http_request_deframer.sv]
// HTTP/1.1 request deframer, one request byte per word.
// A pushed word is queued at the input, then parsed into the result queue.
// Throughput: one word per cycle while the result queue has room.
// Reset (synchronous, i_rst_n low): both queues empty, parser in header phase,
// limits back to 16 KiB of header and 10 MiB of body.
// Depends on hrd_pkg, hrd_front, hrd_back.
module http_request_deframer
    import hrd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input queue side
    input  logic                     push,
    output logic                     full,
    input  logic [7:0]               i_data_byte,
    input  logic                     i_first_of_request,
    input  logic                     i_stream_closed,
    // result queue side
    output logic                     empty,
    input  logic                     pop,
    output logic [2:0]               o_byte_kind,
    output logic [7:0]               o_out_byte,
    output logic [LENGTH_BITS-1:0]   o_body_length,
    output logic                     o_last_of_request,
    output logic [1:0]               o_error_code,
    // configuration
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    logic [HEADER_COUNT_BITS-1:0] r_max_header;
    logic [LENGTH_BITS-1:0]       r_max_body;
    logic                         cls_valid;
    logic                         cls_take;
    t_cls                         cls_word;
    t_res                         res;

    // Limit registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_header <= MAX_HEADER_RESET;
            r_max_body   <= MAX_BODY_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_MAX_HEADER) begin
                r_max_header <= i_cfg_data[HEADER_COUNT_BITS-1:0];
            end else begin
                r_max_body <= i_cfg_data[LENGTH_BITS-1:0];
            end
        end
    end

    hrd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data_byte (i_data_byte),
        .i_first     (i_first_of_request),
        .i_closed    (i_stream_closed),
        .o_full      (full),
        .o_valid     (cls_valid),
        .o_word      (cls_word),
        .i_take      (cls_take)
    );

    hrd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (cls_valid),
        .i_word       (cls_word),
        .o_take       (cls_take),
        .i_max_header (r_max_header),
        .i_max_body   (r_max_body),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_res        (res)
    );

    assign o_byte_kind       = res.kind;
    assign o_out_byte        = res.data;
    assign o_body_length     = res.body_length;
    assign o_last_of_request = res.last;
    assign o_error_code      = res.err;

    // Both queues come out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!full && empty))
        else $error("queues not empty after reset");

    // Every error word ends the request and carries a code
    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_byte_kind == KIND_ERROR) |->
        (o_last_of_request && o_error_code != ERR_NONE))
        else $error("error word without last or code");

    // Non-error words carry no error code
    a_no_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_byte_kind != KIND_ERROR) |-> (o_error_code == ERR_NONE))
        else $error("error code on a non-error word");

    // A terminator that ends the request means an empty body
    a_empty_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_byte_kind == KIND_TERM && o_last_of_request) |->
        (o_body_length == '0))
        else $error("final terminator with nonzero body length");

endmodule

[hdl/hrd_front.sv]
// hrd_front: accepts input bytes, classifies them (CR, LF, digit, lower case)
// and holds them in a two-word queue for the parser. Depends on hrd_pkg.
module hrd_front
    import hrd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_data_byte,
    input  logic       i_first,
    input  logic       i_closed,
    output logic       o_full,
    output logic       o_valid,
    output t_cls       o_word,
    input  logic       i_take
);

    t_cls       n_word;
    t_cls       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       wr_en;
    logic       rd_en;

    // Classify the incoming byte
    always_comb begin
        n_word.data     = i_data_byte;
        n_word.lower    = (i_data_byte inside {[CH_UC_A:CH_UC_Z]}) ?
                          i_data_byte + CASE_OFS : i_data_byte;
        n_word.digit    = 4'(i_data_byte - CH_ZERO);
        n_word.is_cr    = i_data_byte == CH_CR;
        n_word.is_lf    = i_data_byte == CH_LF;
        n_word.is_digit = i_data_byte inside {[CH_ZERO:CH_NINE]};
        n_word.first    = i_first;
        n_word.closed   = i_closed;
    end

    assign o_full  = r_count == 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_word  = r_mem[r_rptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_take && o_valid;

    // Queue storage; payload needs no reset
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= n_word;
        end
    end

    // Queue pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wptr <= !r_wptr;
            end
            if (rd_en) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + 2'(wr_en) - 2'(rd_en);
        end
    end

endmodule

[hdl/hrd_back.sv]
// hrd_back: request parser (header scan, content-length capture, body count)
// and a two-word result queue. Depends on hrd_pkg.
module hrd_back
    import hrd_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  t_cls                         i_word,
    output logic                         o_take,
    input  logic [HEADER_COUNT_BITS-1:0] i_max_header,
    input  logic [LENGTH_BITS-1:0]       i_max_body,
    input  logic                         i_pop,
    output logic                         o_empty,
    output t_res                         o_res
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_BODY,
        PH_DONE,
        PH_STOP
    } t_phase;

    // Parser state
    t_phase                       r_phase,  n_phase,  c_phase;
    logic [1:0]                   r_term,   n_term,   c_term;
    logic [POS_BITS-1:0]          r_pos,    n_pos,    c_pos;
    logic                         r_pok,    n_pok,    c_pok;
    logic                         r_inlen,  n_inlen,  c_inlen;
    logic [ACC_BITS-1:0]          r_dv,     n_dv,     c_dv;
    logic [DIGIT_CNT_BITS-1:0]    r_dc,     n_dc,     c_dc;
    logic [LENGTH_BITS-1:0]       r_len,    n_len,    c_len;
    logic [HEADER_COUNT_BITS-1:0] r_hdr,    n_hdr,    c_hdr;
    logic [LENGTH_BITS-1:0]       r_bc,     n_bc,     c_bc;

    logic [HEADER_COUNT_BITS:0]   hdr_inc;
    logic [MUL_BITS-1:0]          acc_mul;
    logic                         prefix_hit;
    logic                         term_done;
    t_res                         n_res;

    // Result queue
    t_res                         r_mem [2];
    logic                         r_wptr;
    logic                         r_rptr;
    logic [1:0]                   r_count;
    logic                         rd_en;

    assign o_take  = i_valid && (r_count != 2'd2);
    assign o_empty = r_count == 2'd0;
    assign o_res   = r_mem[r_rptr];
    assign rd_en   = i_pop && !o_empty;

    // State as seen by this word: a new request starts from cleared state
    always_comb begin
        if (i_word.first) begin
            c_phase = PH_HEADER;
            c_term  = 2'd0;
            c_pos   = '0;
            c_pok   = 1'b1;
            c_inlen = 1'b0;
            c_dv    = '0;
            c_dc    = '0;
            c_len   = '0;
            c_hdr   = '0;
            c_bc    = '0;
        end else begin
            c_phase = r_phase;
            c_term  = r_term;
            c_pos   = r_pos;
            c_pok   = r_pok;
            c_inlen = r_inlen;
            c_dv    = r_dv;
            c_dc    = r_dc;
            c_len   = r_len;
            c_hdr   = r_hdr;
            c_bc    = r_bc;
        end
    end

    assign hdr_inc    = {1'b0, c_hdr} + 1'b1;
    assign acc_mul    = (MUL_BITS'(c_dv) << 3) + (MUL_BITS'(c_dv) << 1)
                      + MUL_BITS'(i_word.digit);
    assign prefix_hit = c_pok && (i_word.lower == prefix_char(c_pos));

    // Per-byte parser step
    always_comb begin
        n_phase   = c_phase;
        n_term    = c_term;
        n_pos     = c_pos;
        n_pok     = c_pok;
        n_inlen   = c_inlen;
        n_dv      = c_dv;
        n_dc      = c_dc;
        n_len     = c_len;
        n_hdr     = c_hdr;
        n_bc      = c_bc;
        term_done = 1'b0;

        n_res.kind        = KIND_IGNORED;
        n_res.data        = i_word.data;
        n_res.last        = 1'b0;
        n_res.err         = ERR_NONE;

        if (i_word.closed) begin
            n_res.data = 8'h00;
            if (c_phase == PH_HEADER || c_phase == PH_BODY) begin
                n_phase    = PH_STOP;
                n_res.kind = KIND_ERROR;
                n_res.last = 1'b1;
                n_res.err  = ERR_CLOSED;
            end
        end else begin
            case (c_phase)
                PH_HEADER: begin
                    if (hdr_inc > {1'b0, i_max_header} || hdr_inc[HEADER_COUNT_BITS]) begin
                        // header limit, checked before anything else
                        n_phase    = PH_STOP;
                        n_res.kind = KIND_ERROR;
                        n_res.last = 1'b1;
                        n_res.err  = ERR_HEADER;
                    end else begin
                        n_hdr = hdr_inc[HEADER_COUNT_BITS-1:0];

                        // CR LF CR LF tracker
                        if (i_word.is_cr) begin
                            n_term = (c_term == 2'd2) ? 2'd3 : 2'd1;
                        end else if (i_word.is_lf) begin
                            term_done = c_term == 2'd3;
                            n_term    = (c_term == 2'd1) ? 2'd2 : 2'd0;
                        end else begin
                            n_term = 2'd0;
                        end

                        // line tracking: prefix match, then digit capture
                        if (i_word.is_lf) begin
                            n_pos   = '0;
                            n_pok   = 1'b1;
                            n_inlen = 1'b0;
                        end else if (c_pos < POS_BITS'(PREFIX_LEN)) begin
                            n_pok = prefix_hit;
                            n_pos = c_pos + 1'b1;
                            if (c_pos == POS_BITS'(PREFIX_LEN - 1) && prefix_hit) begin
                                n_inlen = 1'b1;
                                n_dv    = '0;
                                n_dc    = '0;
                            end
                        end else if (c_inlen && i_word.is_digit &&
                                     c_dc < DIGIT_CNT_BITS'(MAX_DIGITS)) begin
                            n_dv = (acc_mul > MUL_BITS'(LEN_SAT)) ? LEN_SAT
                                                                  : acc_mul[ACC_BITS-1:0];
                            n_dc = c_dc + 1'b1;
                        end

                        if (!term_done) begin
                            n_res.kind = KIND_HEADER;
                        end else if (n_dv[LENGTH_BITS] ||
                                     n_dv[LENGTH_BITS-1:0] > i_max_body) begin
                            n_phase    = PH_STOP;
                            n_res.kind = KIND_ERROR;
                            n_res.last = 1'b1;
                            n_res.err  = ERR_BODY;
                        end else begin
                            n_len      = n_dv[LENGTH_BITS-1:0];
                            n_bc       = '0;
                            n_res.kind = KIND_TERM;
                            if (n_dv[LENGTH_BITS-1:0] == '0) begin
                                n_phase    = PH_DONE;
                                n_res.last = 1'b1;
                            end else begin
                                n_phase = PH_BODY;
                            end
                        end
                    end
                end
                PH_BODY: begin
                    n_bc       = c_bc + 1'b1;
                    n_res.kind = KIND_BODY;
                    if (n_bc >= c_len) begin
                        n_phase    = PH_DONE;
                        n_res.last = 1'b1;
                    end
                end
                default: begin
                    n_res.kind = KIND_IGNORED;
                end
            endcase
        end

        n_res.body_length = n_len;
    end

    // Result storage; payload needs no reset
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_mem[r_wptr] <= n_res;
        end
    end

    // Parser state and result queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_term  <= 2'd0;
            r_pos   <= '0;
            r_pok   <= 1'b1;
            r_inlen <= 1'b0;
            r_dv    <= '0;
            r_dc    <= '0;
            r_len   <= '0;
            r_hdr   <= '0;
            r_bc    <= '0;
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (o_take) begin
                r_phase <= n_phase;
                r_term  <= n_term;
                r_pos   <= n_pos;
                r_pok   <= n_pok;
                r_inlen <= n_inlen;
                r_dv    <= n_dv;
                r_dc    <= n_dc;
                r_len   <= n_len;
                r_hdr   <= n_hdr;
                r_bc    <= n_bc;
                r_wptr  <= !r_wptr;
            end
            if (rd_en) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + 2'(o_take) - 2'(rd_en);
        end
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: self-checking testbench for http_request_deframer. Streams request
// bytes through the input queue, predicts every result word and checks it.
// Depends on hrd_pkg and the deframer sources under hdl.
module tb_top;
    import hrd_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int IDLE_PCT    = 28;
    localparam int DRAIN_WAIT  = 4;
    localparam int TAIL_WAIT   = 8;
    localparam int HOLD_CYCLES = 400;
    localparam logic [8*PREFIX_LEN-1:0] LEN_PREFIX = "content-length:";

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_BODY,
        PH_DONE,
        PH_STOPPED
    } t_phase;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     push;
    logic                     full;
    logic [7:0]               i_data_byte;
    logic                     i_first_of_request;
    logic                     i_stream_closed;
    logic                     empty;
    logic                     pop = 1'b0;
    logic [2:0]               o_byte_kind;
    logic [7:0]               o_out_byte;
    logic [LENGTH_BITS-1:0]   o_body_length;
    logic                     o_last_of_request;
    logic [1:0]               o_error_code;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    http_request_deframer dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_data_byte        (i_data_byte),
        .i_first_of_request (i_first_of_request),
        .i_stream_closed    (i_stream_closed),
        .empty              (empty),
        .pop                (pop),
        .o_byte_kind        (o_byte_kind),
        .o_out_byte         (o_out_byte),
        .o_body_length      (o_body_length),
        .o_last_of_request  (o_last_of_request),
        .o_error_code       (o_error_code),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Parser mirror and limits
    t_phase                   ph;
    logic [1:0]               crlf_seen;
    logic [POS_BITS-1:0]      line_pos;
    logic                     prefix_match;
    logic                     len_line;
    logic [ACC_BITS-1:0]      digits_val;
    logic [DIGIT_CNT_BITS-1:0] digits_cnt;
    logic [LENGTH_BITS-1:0]   latched_len;
    logic [HEADER_COUNT_BITS-1:0] hdr_bytes;
    logic [LENGTH_BITS-1:0]   body_bytes;
    logic [HEADER_COUNT_BITS-1:0] lim_header;
    logic [LENGTH_BITS-1:0]   lim_body;

    t_res frames_due[$];

    // Run bookkeeping
    int  mismatches = 0;
    int  bytes_sent = 0;
    int  frames_checked = 0;
    int  requests = 0;
    int  limit_writes = 0;
    int  cycles = 0;
    int  stall_cycles = 0;
    int  tx_idle_pct = IDLE_PCT;
    int  rx_idle_pct = IDLE_PCT;
    int  rx_hold_req = 0;
    int  rx_hold_left = 0;
    logic new_req = 1'b0;

    function automatic void clear_parser();
        ph           = PH_HEADER;
        crlf_seen    = '0;
        line_pos     = '0;
        prefix_match = 1'b1;
        len_line     = 1'b0;
        digits_val   = '0;
        digits_cnt   = '0;
        latched_len  = '0;
        hdr_bytes    = '0;
        body_bytes   = '0;
    endfunction

    function automatic t_res frame_word(input t_kind k, input logic [7:0] d,
                                        input logic last, input t_err e);
        t_res r;
        r.kind        = k;
        r.data        = d;
        r.body_length = latched_len;
        r.last        = last;
        r.err         = e;
        return r;
    endfunction

    // Framing result of one accepted byte; advances the parser mirror
    function automatic t_res frame_byte(input logic [7:0] b, input logic first,
                                        input logic closed);
        logic [HEADER_COUNT_BITS:0] cnt;
        logic [7:0]  lc;
        logic [63:0] acc;
        logic        term;
        if (first) clear_parser();

        if (closed) begin
            if (ph == PH_HEADER || ph == PH_BODY) begin
                ph = PH_STOPPED;
                return frame_word(KIND_ERROR, 8'h00, 1'b1, ERR_CLOSED);
            end
            return frame_word(KIND_IGNORED, 8'h00, 1'b0, ERR_NONE);
        end

        if (ph == PH_HEADER) begin
            cnt = {1'b0, hdr_bytes} + 1'b1;
            if (cnt > {1'b0, lim_header} || cnt[HEADER_COUNT_BITS]) begin
                ph = PH_STOPPED;
                return frame_word(KIND_ERROR, b, 1'b1, ERR_HEADER);
            end
            hdr_bytes = cnt[HEADER_COUNT_BITS-1:0];

            // CR LF CR LF hunt
            term = 1'b0;
            if (b == CH_CR) begin
                crlf_seen = (crlf_seen == 2'd2) ? 2'd3 : 2'd1;
            end else if (b == CH_LF) begin
                term = (crlf_seen == 2'd3);
                crlf_seen = (crlf_seen == 2'd1) ? 2'd2 : 2'd0;
            end else begin
                crlf_seen = 2'd0;
            end

            // length-line detection and digit accumulation
            if (b == CH_LF) begin
                line_pos     = '0;
                prefix_match = 1'b1;
                len_line     = 1'b0;
            end else if (line_pos < PREFIX_LEN) begin
                lc = (b >= CH_UC_A && b <= CH_UC_Z) ? b + CASE_OFS : b;
                if (lc != LEN_PREFIX[8*(PREFIX_LEN-1-int'(line_pos)) +: 8])
                    prefix_match = 1'b0;
                line_pos++;
                if (line_pos == PREFIX_LEN && prefix_match) begin
                    len_line   = 1'b1;
                    digits_val = '0;
                    digits_cnt = '0;
                end
            end else if (len_line && b >= CH_ZERO && b <= CH_NINE
                         && digits_cnt < MAX_DIGITS) begin
                acc = 64'(digits_val) * 64'd10 + 64'(b - CH_ZERO);
                digits_val = (acc > 64'(LEN_SAT)) ? LEN_SAT : acc[ACC_BITS-1:0];
                digits_cnt++;
            end

            if (!term)
                return frame_word(KIND_HEADER, b, 1'b0, ERR_NONE);
            if (digits_val >= LEN_SAT || digits_val > {1'b0, lim_body}) begin
                ph = PH_STOPPED;
                return frame_word(KIND_ERROR, b, 1'b1, ERR_BODY);
            end
            latched_len = digits_val[LENGTH_BITS-1:0];
            body_bytes  = '0;
            if (latched_len == '0) begin
                ph = PH_DONE;
                return frame_word(KIND_TERM, b, 1'b1, ERR_NONE);
            end
            ph = PH_BODY;
            return frame_word(KIND_TERM, b, 1'b0, ERR_NONE);
        end

        if (ph == PH_BODY) begin
            body_bytes++;
            if (body_bytes >= latched_len) begin
                ph = PH_DONE;
                return frame_word(KIND_BODY, b, 1'b1, ERR_NONE);
            end
            return frame_word(KIND_BODY, b, 1'b0, ERR_NONE);
        end

        return frame_word(KIND_IGNORED, b, 1'b0, ERR_NONE);
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // Result side: check each popped word, then pick pop for the next cycle
    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (frames_due.size() == 0) begin
                    $display("%0t: result word with nothing pending, expected none, actual kind %0d byte %0d",
                             $time, o_byte_kind, o_out_byte);
                    mismatches++;
                end else begin
                    want = frames_due.pop_front();
                    check_field("byte_kind", want.kind, o_byte_kind);
                    check_field("out_byte", want.data, o_out_byte);
                    check_field("body_length", want.body_length, o_body_length);
                    check_field("last_of_request", want.last, o_last_of_request);
                    check_field("error_code", want.err, o_error_code);
                    frames_checked++;
                end
            end
            if (rx_hold_req > 0) begin
                rx_hold_left = rx_hold_req;
                rx_hold_req  = 0;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog and stall count
    always @(posedge i_clk) begin
        cycles++;
        if (push && full) stall_cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: no finish within %0d cycles, %0d words pending",
                     $time, CYCLE_LIMIT, frames_due.size());
            $display("tb_top failed");
            $finish;
        end
    end

    // Offer one word, with random idle cycles ahead of it, until accepted
    task automatic send_word(input logic [7:0] b, input logic first, input logic closed);
        if ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        push               <= 1'b1;
        i_data_byte        <= b;
        i_first_of_request <= first;
        i_stream_closed    <= closed;
        @(posedge i_clk);
        while (full !== 1'b0) @(posedge i_clk);
        frames_due.push_back(frame_byte(b, first, closed));
        bytes_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_word(b, new_req, 1'b0);
        new_req = 1'b0;
    endtask

    task automatic send_eol(input bit bare);
        if (!bare) send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    // Stop offering, let every pending word come out, then a short pause
    task automatic wait_idle();
        push <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [CFG_IDX_BITS-1:0] idx,
                               input logic [CFG_DATA_BITS-1:0] val);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_MAX_HEADER)
            lim_header = val[HEADER_COUNT_BITS-1:0];
        else
            lim_body = val;
        limit_writes++;
    endtask

    task automatic set_limits(input logic [CFG_DATA_BITS-1:0] hdr,
                              input logic [CFG_DATA_BITS-1:0] body);
        write_limit(CFG_MAX_HEADER, hdr);
        write_limit(CFG_MAX_BODY, body);
    endtask

    // Printable junk line; may carry digits, which must not count
    task automatic send_junk_line(input bit bare);
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(33, 126)));
        send_eol(bare);
    endtask

    // Length line in random letter case, optionally broken in one place
    task automatic send_length_line(input string num, input bit mangle, input bit bare);
        logic [7:0] ch;
        int         bad_pos;
        bad_pos = mangle ? $urandom_range(0, PREFIX_LEN - 1) : -1;
        for (int k = 0; k < PREFIX_LEN; k++) begin
            ch = LEN_PREFIX[8*(PREFIX_LEN-1-k) +: 8];
            if (ch >= "a" && ch <= "z" && $urandom_range(1)) ch = ch - CASE_OFS;
            if (k == bad_pos) ch = "q";
            send_byte(ch);
        end
        if ($urandom_range(3) == 0) send_byte(" ");
        for (int k = 0; k < num.len(); k++) begin
            send_byte(num[k]);
            if ($urandom_range(15) == 0) send_byte(" ");
        end
        send_eol(bare);
    endtask

    // One request: header lines, terminator, body, maybe trailing bytes
    task automatic send_request();
        int    pick;
        int    body_size;
        int    close_at;
        int    zeros;
        bit    has_len;
        string num;
        new_req   = 1'b1;
        has_len   = 1'b1;
        pick      = $urandom_range(99);
        body_size = (pick < 10) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        num       = $sformatf("%0d", body_size);
        requests++;

        if (pick >= 90 && pick < 94) begin
            // lengths at and beyond the limits
            case ($urandom_range(3))
                0:       num = "16777216";
                1:       num = "16777215";
                2:       num = "99999999999";
                default: num = $sformatf("%0d", lim_body + 25'd1);
            endcase
            body_size = 2;
        end else if (pick >= 94 && pick < 96) begin
            num       = "";
            body_size = 0;
        end else if (pick >= 96 && pick < 98) begin
            // leading zeros, at times more digits than are counted
            zeros = $urandom_range(28, 34);
            num   = "";
            repeat (zeros) num = {num, "0"};
            num       = {num, "5"};
            body_size = 5;
        end else if (pick >= 98) begin
            has_len = 1'b0;
        end

        send_junk_line(1'b0);
        if ($urandom_range(24) == 0) begin
            send_word(8'($urandom_range(255)), 1'b0, 1'b1);
            return;
        end
        if ($urandom_range(4) == 0)
            send_length_line($sformatf("%0d", $urandom_range(999)), 1'b0,
                             $urandom_range(4) == 0);
        repeat ($urandom_range(0, 2)) send_junk_line($urandom_range(4) == 0);
        if (has_len)
            send_length_line(num, $urandom_range(11) == 0, 1'b0);
        else
            send_junk_line(1'b0);
        if ($urandom_range(6) == 0) send_junk_line(1'b0);
        send_eol(1'b0);

        close_at = ($urandom_range(9) == 0) ? $urandom_range(0, body_size) : -1;
        for (int k = 0; k < body_size; k++) begin
            if (k == close_at) begin
                send_word(8'($urandom_range(255)), 1'b0, 1'b1);
                return;
            end
            send_byte(8'($urandom_range(255)));
        end
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(255)));
        if ($urandom_range(7) == 0) send_word(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    task automatic send_noise(input int n);
        repeat (n) send_word(8'($urandom_range(255)), $urandom_range(9) == 0,
                             $urandom_range(11) == 0);
    endtask

    task automatic run_traffic(input int count);
        int goal;
        goal = bytes_sent + count;
        while (bytes_sent < goal) begin
            if ($urandom_range(9) == 0)
                send_noise($urandom_range(1, 6));
            else
                send_request();
        end
    endtask

    // Directed: header limit hit on the byte that would end the header
    task automatic test_header_limit();
        write_limit(CFG_MAX_HEADER, 24'd3);
        new_req = 1'b1;
        send_eol(1'b0);
        send_eol(1'b0);
        send_word("Z", 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
        write_limit(CFG_MAX_HEADER, 24'd65536);
    endtask

    // Directed: bare terminator, zero length, trailing bytes ignored
    task automatic test_empty_body();
        new_req = 1'b1;
        send_eol(1'b0);
        send_eol(1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
    endtask

    // Directed: close inside the header, then a close once stopped
    task automatic test_early_close();
        send_word(8'hA5, 1'b1, 1'b0);
        send_word(8'hFF, 1'b0, 1'b1);
        send_word(8'h5A, 1'b0, 1'b1);
    endtask

    task automatic test_wide_limits();
        set_limits(24'd65536, 24'd16777215);
        run_traffic(170);
    endtask

    task automatic test_tight_limits();
        set_limits(24'd40, 24'd0);
        run_traffic(110);
    endtask

    task automatic test_smallest_header();
        set_limits(24'd1, 24'd5);
        run_traffic(40);
    endtask

    task automatic test_random_limits();
        repeat (4) begin
            set_limits(24'($urandom_range(16, 300)), 24'($urandom_range(0, 40)));
            run_traffic(35);
        end
    endtask

    task automatic test_calm_stretch();
        set_limits(24'd16384, 24'd10485760);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_traffic(120);
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;
    endtask

    // Receiver holds off while the sender keeps pushing: queues fill, full rises
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_hold_req = HOLD_CYCLES;
        run_traffic(100);
        tx_idle_pct = IDLE_PCT;
    endtask

    task automatic test_default_limits();
        run_traffic(100);
    endtask

    initial begin
        i_rst_n            = 1'b0;
        push               = 1'b0;
        i_data_byte        = '0;
        i_first_of_request = 1'b0;
        i_stream_closed    = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = '0;
        i_cfg_data         = '0;
        lim_header         = 17'd16384;
        lim_body           = 24'd10485760;
        clear_parser();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_header_limit();
        test_empty_body();
        test_early_close();
        test_wide_limits();
        test_tight_limits();
        test_smallest_header();
        test_random_limits();
        test_calm_stretch();
        test_backpressure();
        test_default_limits();

        push <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);

        $display("Streamed %0d bytes over %0d requests with %0d limit writes; %0d words checked.",
                 bytes_sent, requests, limit_writes, frames_checked);
        $display("Input held off by full for %0d cycles; %0d mismatches.",
                 stall_cycles, mismatches);
        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

[filelist.f]
hdl/hrd_pkg.sv
hdl/hrd_front.sv
hdl/hrd_back.sv
hdl/http_request_deframer.sv
tb/tb_top.sv
